>>> rtl/csq_pkg.sv
// ----------------------------------------------------------------------------
// csq_pkg: shared types and constants for the counting semaphore
// Holds payload structs, controller/datapath command and status bundles,
// operation codes and register map constants.
// ----------------------------------------------------------------------------
package csq_pkg;

    // Default depth of the wait queue.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths.
    localparam int OP_W    = 2;
    localparam int TASK_W  = 8;
    localparam int COUNT_W = 16;

    // Register port geometry.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WAIT   = 2'd0;
    localparam logic [OP_W-1:0] OP_SIGNAL = 2'd1;
    localparam logic [OP_W-1:0] OP_BCAST  = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

    // Register indexes (taken from the word address bit).
    localparam logic REG_INIT_COUNT = 1'b0;
    localparam logic REG_MAX_COUNT  = 1'b1;

    // One input transaction.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TASK_W-1:0] task_id;
    } t_csq_in;

    // One result transaction.
    typedef struct packed {
        logic               granted;
        logic               blocked;
        logic               queue_overflow;
        logic               woke;
        logic [TASK_W-1:0]  woken_task;
        logic [COUNT_W-1:0] count_now;
        logic               last;
    } t_csq_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the incoming item
        logic take;     // wait takes a token
        logic push;     // wait enters the queue
        logic drop;     // wait dropped, queue full
        logic pop;      // remove the oldest waiter
        logic raise;    // raise the count toward the ceiling
        logic emit;     // load the output register
        logic last;     // final result of this item
    } t_csq_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            count_nz;
        logic            fill_zero;
        logic            fill_one;
        logic            fill_full;
        logic            out_free;
    } t_csq_sts;

endpackage

>>> rtl/csq_ctrl.sv
// ----------------------------------------------------------------------------
// csq_ctrl: sequencing state machine for the counting semaphore
// Accepts one item at a time, decides what each step does from the
// datapath status and walks the queue for a broadcast.
// ----------------------------------------------------------------------------
module csq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  csq_pkg::t_csq_sts i_sts,
    output csq_pkg::t_csq_cmd o_cmd,
    output logic              o_idle
);
    import csq_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_BWAIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_idle = (r_state == S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                    case (i_sts.op)
                        OP_WAIT: begin
                            if (i_sts.count_nz) begin
                                o_cmd.take = 1'b1;
                            end else if (!i_sts.fill_full) begin
                                o_cmd.push = 1'b1;
                            end else begin
                                o_cmd.drop = 1'b1;
                            end
                        end
                        OP_SIGNAL: begin
                            o_cmd.pop   = !i_sts.fill_zero;
                            o_cmd.raise = 1'b1;
                        end
                        OP_BCAST: begin
                            if (!i_sts.fill_zero) begin
                                o_cmd.pop   = 1'b1;
                                o_cmd.raise = 1'b1;
                                o_cmd.last  = i_sts.fill_one;
                                // More waiters: let the read port fetch the new head.
                                if (!i_sts.fill_one) begin
                                    n_state = S_BWAIT;
                                end
                            end
                        end
                        default: begin
                            // Reserved code gives one plain result.
                        end
                    endcase
                end
            end
            S_BWAIT: begin
                n_state = S_EXEC;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/csq_dp.sv
// ----------------------------------------------------------------------------
// csq_dp: datapath of the counting semaphore
// Token count, configuration registers, circular wait queue in a memory
// with a registered read port, and the result register.
// ----------------------------------------------------------------------------
module csq_dp #(
    parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  csq_pkg::t_csq_cmd           i_cmd,
    input  csq_pkg::t_csq_in            i_in_data,
    input  logic                        i_cfg_wr,
    input  logic                        i_cfg_idx,
    input  logic [csq_pkg::APB_DW-1:0]  i_cfg_wdata,
    input  logic                        i_cfg_rd_idx,
    output logic [csq_pkg::APB_DW-1:0]  o_cfg_rdata,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output csq_pkg::t_csq_out           o_out_data,
    output csq_pkg::t_csq_sts           o_sts
);
    import csq_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
    localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);

    logic [COUNT_W-1:0] r_init_cnt;
    logic [COUNT_W-1:0] r_max_cnt;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [PTR_W-1:0]   r_head;
    logic [PTR_W-1:0]   r_tail;
    logic [FILL_W-1:0]  r_fill;
    logic [TASK_W-1:0]  r_mem [QUEUE_DEPTH];
    logic [TASK_W-1:0]  r_rd_data;
    t_csq_in            r_item;
    logic               r_out_valid;
    t_csq_out           r_out;

    // Status toward the controller.
    assign o_sts.op        = r_item.op;
    assign o_sts.count_nz  = (r_count != '0);
    assign o_sts.fill_zero = (r_fill == '0);
    assign o_sts.fill_one  = (r_fill == FILL_ONE);
    assign o_sts.fill_full = (r_fill == FILL_FULL);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // Register read-back.
    assign o_cfg_rdata = (i_cfg_rd_idx == REG_MAX_COUNT)
                       ? {{(APB_DW-COUNT_W){1'b0}}, r_max_cnt}
                       : {{(APB_DW-COUNT_W){1'b0}}, r_init_cnt};

    // Count after this step: a take lowers it, a raise stops at the ceiling.
    always_comb begin
        n_count = r_count;
        if (i_cmd.take) begin
            n_count = r_count - COUNT_W'(1);
        end else if (i_cmd.raise && (r_count < r_max_cnt)) begin
            n_count = r_count + COUNT_W'(1);
        end
    end

    // Configuration registers, count and queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_cnt <= '0;
            r_max_cnt  <= COUNT_W'(1);
            r_count    <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
        end else if (i_cfg_wr) begin
            if (i_cfg_idx == REG_INIT_COUNT) begin
                r_init_cnt <= i_cfg_wdata[COUNT_W-1:0];
                r_count    <= i_cfg_wdata[COUNT_W-1:0];
                r_head     <= '0;
                r_tail     <= '0;
                r_fill     <= '0;
            end else begin
                r_max_cnt <= i_cfg_wdata[COUNT_W-1:0];
            end
        end else begin
            r_count <= n_count;
            if (i_cmd.push) begin
                r_tail <= (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
                r_fill <= r_fill + FILL_W'(1);
            end else if (i_cmd.pop) begin
                r_head <= (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

    // Waiter memory: one write port at the tail, registered read at the head.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= r_item.task_id;
        end
        r_rd_data <= r_mem[r_head];
    end

    // Item holding register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.granted        <= i_cmd.take;
            r_out.blocked        <= i_cmd.push;
            r_out.queue_overflow <= i_cmd.drop;
            r_out.woke           <= i_cmd.pop;
            r_out.woken_task     <= i_cmd.pop ? r_rd_data : '0;
            r_out.count_now      <= n_count;
            r_out.last           <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/counting_semaphore_wait_queue.sv
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue: counting semaphore with a FIFO wait queue
// Wait, signal and broadcast operations on a token count; blocked tasks
// are held in a circular queue and woken oldest first.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_in_valid/o_in_stall  i_in_data  (op, task_id)
//   output    out        o_out_valid/i_out_stall o_out_data (seven fields)
//   config    in         APB psel/penable      paddr, pwdata, prdata
//
// Wait, signal and the reserved code are accepted and then executed. A
// broadcast pops one waiter per execute step, with a wait step between
// pops, and gives one plain result when the queue is empty; the
// registered read port of the waiter memory presents the new head only
// after each pop. Reset is synchronous; the memory is not cleared.
// A stall on the output holds the execute step until the result register
// frees; the next item is accepted while a finished result still waits.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue #(
    parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  csq_pkg::t_csq_in            i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output csq_pkg::t_csq_out           o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [csq_pkg::APB_AW-1:0]  paddr,
    input  logic [csq_pkg::APB_DW-1:0]  pwdata,
    output logic [csq_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import csq_pkg::*;

    t_csq_cmd w_cmd;
    t_csq_sts w_sts;
    logic     w_idle;
    logic     w_cfg_wr;

    // Register write completes in the access phase.
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign o_in_stall = !w_idle;

    csq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idle     (w_idle)
    );

    csq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_in_data    (i_in_data),
        .i_cfg_wr     (w_cfg_wr),
        .i_cfg_idx    (paddr[2]),
        .i_cfg_wdata  (pwdata),
        .i_cfg_rd_idx (paddr[2]),
        .o_cfg_rdata  (prdata),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .o_sts        (w_sts)
    );

endmodule
